// ===== hdl/sensor_round_robin_moving_average_defines.svh =====
// Assertion macros shared by the sensor averaging RTL.
`ifndef SENSOR_ROUND_ROBIN_MOVING_AVERAGE_DEFINES_SVH
`define SENSOR_ROUND_ROBIN_MOVING_AVERAGE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SRRMA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("srrma: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define SRRMA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("srrma: next-cycle check failed");

`endif

// ===== hdl/srrma_pkg.sv =====
// Shared types and constants for the sensor averaging block.
package srrma_pkg;

   localparam int SAMPLE_BITS = 12;
   localparam int TRIM_BITS   = 7;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [TRIM_BITS-1:0] LEFT_TRIM_RESET  = 7'h7A;
   localparam logic [TRIM_BITS-1:0] RIGHT_TRIM_RESET = 7'h06;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_LEFT_TRIM  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RIGHT_TRIM = 2'd1;

   typedef enum logic [1:0] {
      CH_LEFT    = 2'd0,
      CH_RIGHT   = 2'd1,
      CH_BATTERY = 2'd2,
      CH_THUMB   = 2'd3
   } channel_type;

   typedef struct packed {
      logic push;
      logic load;
   } window_ctrl_type;

endpackage

// ===== hdl/sensor_round_robin_moving_average.sv =====
// Round-robin sensor sampler with trimmed left/right moving averages.
// Usage:
//   req_* carries one converter sample per transfer; channels are visited in the
//   fixed order left, right, battery, thumb, then back to left.
//   rsp_* returns one result per sample: channel, trimmed sample and the left
//   and right means as they stand after that sample.
//   csr_* writes the signed left (index 0) and right (index 1) trims; other
//   indexes are ignored. Write only while no sample is in flight.
// Pipeline: req transfer -> trim -> window push -> mean multiply -> rsp.
//   Throughput: one sample per cycle while no stall holds the pipeline, set by
//   the single push of the cell chain and one reciprocal multiply per side.
// Reset: synchronous, active high; windows, sums and means clear to zero, the
//   channel order restarts at left, and trims return to -6 and +6.
// Stall: while rsp_tready is low with a result waiting, the whole pipeline
//   holds and req_tready drops; nothing is lost or repeated.
`include "sensor_round_robin_moving_average_defines.svh"
module sensor_round_robin_moving_average #(
   parameter int WINDOW_DEPTH = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [15:0]                          req_tdata,  // [11:0] sample
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [1:0] channel, [13:2] trimmed_sample, [25:14] left_average,
   // [37:26] right_average, [39:38] zero
   output logic [39:0]                          rsp_tdata,
   input  logic                                 csr_we,
   input  logic [srrma_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [srrma_pkg::TRIM_BITS-1:0]      csr_wdata
);
   import srrma_pkg::*;

   localparam int EXT_W = SAMPLE_BITS + 2;

   logic [TRIM_BITS-1:0]   left_trim_ff, left_trim_in;
   logic [TRIM_BITS-1:0]   right_trim_ff, right_trim_in;
   channel_type            counter_ff, counter_in;

   logic                   v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   channel_type            ch1_ff, ch1_in, ch2_ff, ch2_in, ch3_ff, ch3_in;
   logic [SAMPLE_BITS-1:0] t1_ff, t1_in, t2_ff, t2_in, t3_ff, t3_in;

   logic                   en;
   logic                   req_xfer;
   logic [SAMPLE_BITS-1:0] sample;
   logic [TRIM_BITS-1:0]   trim_sel;
   logic [EXT_W-1:0]       trim_ext;
   logic [EXT_W-1:0]       trim_sum;
   logic [SAMPLE_BITS-1:0] trimmed;

   window_ctrl_type        left_ctrl, right_ctrl;
   logic [SAMPLE_BITS-1:0] left_mean, right_mean;

   assign en         = !v3_ff || rsp_tready;
   assign req_tready = en;
   assign req_xfer   = req_tvalid && en;
   assign sample     = req_tdata[SAMPLE_BITS-1:0];

   always_comb begin
      trim_sel = (counter_ff == CH_LEFT) ? left_trim_ff : right_trim_ff;
      trim_ext = {{(EXT_W-TRIM_BITS){trim_sel[TRIM_BITS-1]}}, trim_sel};
      trim_sum = {2'b00, sample} + trim_ext;
      if (counter_ff == CH_LEFT || counter_ff == CH_RIGHT) begin
         if (trim_sum[EXT_W-1]) begin
            trimmed = '0;
         end else if (trim_sum[EXT_W-2]) begin
            trimmed = '1;
         end else begin
            trimmed = trim_sum[SAMPLE_BITS-1:0];
         end
      end else begin
         trimmed = sample;
      end
   end

   always_comb begin
      left_trim_in  = left_trim_ff;
      right_trim_in = right_trim_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_LEFT_TRIM:  left_trim_in  = csr_wdata;
            CSR_RIGHT_TRIM: right_trim_in = csr_wdata;
            default: ;
         endcase
      end
      counter_in = req_xfer ? channel_type'(2'(counter_ff + 2'd1)) : counter_ff;

      v1_in = v1_ff; ch1_in = ch1_ff; t1_in = t1_ff;
      v2_in = v2_ff; ch2_in = ch2_ff; t2_in = t2_ff;
      v3_in = v3_ff; ch3_in = ch3_ff; t3_in = t3_ff;
      if (en) begin
         v1_in = req_tvalid; ch1_in = counter_ff; t1_in = trimmed;
         v2_in = v1_ff;      ch2_in = ch1_ff;     t2_in = t1_ff;
         v3_in = v2_ff;      ch3_in = ch2_ff;     t3_in = t2_ff;
      end

      left_ctrl.push  = en && v1_ff && ch1_ff == CH_LEFT;
      left_ctrl.load  = en && v2_ff && ch2_ff == CH_LEFT;
      right_ctrl.push = en && v1_ff && ch1_ff == CH_RIGHT;
      right_ctrl.load = en && v2_ff && ch2_ff == CH_RIGHT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_trim_ff  <= LEFT_TRIM_RESET;
         right_trim_ff <= RIGHT_TRIM_RESET;
         counter_ff    <= CH_LEFT;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
      end else begin
         left_trim_ff  <= left_trim_in;
         right_trim_ff <= right_trim_in;
         counter_ff    <= counter_in;
         v1_ff         <= v1_in;
         v2_ff         <= v2_in;
         v3_ff         <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      ch1_ff <= ch1_in; t1_ff <= t1_in;
      ch2_ff <= ch2_in; t2_ff <= t2_in;
      ch3_ff <= ch3_in; t3_ff <= t3_in;
   end

   srrma_window #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_left (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (left_ctrl),
      .sample_in (t1_ff),
      .mean_out  (left_mean)
   );

   srrma_window #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_right (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (right_ctrl),
      .sample_in (t1_ff),
      .mean_out  (right_mean)
   );

   assign rsp_tvalid = v3_ff;
   assign rsp_tdata  = {2'b00, right_mean, left_mean, t3_ff, ch3_ff};

   `SRRMA_ASSERT_NOW(a_stall_blocks_input, clock, reset, rsp_tvalid && !rsp_tready, !req_tready)
   `SRRMA_ASSERT_NEXT(a_counter_on_xfer, clock, reset, !(req_tvalid && req_tready),
                      counter_ff == $past(counter_ff))

endmodule

// ===== hdl/srrma_cell.sv =====
// One window entry: holds a sample and hands it to the next cell on a push.
module srrma_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            shift,
   input  logic [srrma_pkg::SAMPLE_BITS-1:0] d_in,
   output logic [srrma_pkg::SAMPLE_BITS-1:0] q_out
);
   import srrma_pkg::*;

   logic [SAMPLE_BITS-1:0] q_ff;
   logic [SAMPLE_BITS-1:0] q_in;

   always_comb begin
      q_in = shift ? d_in : q_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff <= '0;
      end else begin
         q_ff <= q_in;
      end
   end

   assign q_out = q_ff;

endmodule

// ===== hdl/srrma_window.sv =====
// Sample window: chain of cells, running sum and registered mean.
`include "sensor_round_robin_moving_average_defines.svh"
module srrma_window #(
   parameter int WINDOW_DEPTH = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  srrma_pkg::window_ctrl_type        ctrl,
   input  logic [srrma_pkg::SAMPLE_BITS-1:0] sample_in,
   output logic [srrma_pkg::SAMPLE_BITS-1:0] mean_out
);
   import srrma_pkg::*;

   localparam int DEPTH_LOG  = $clog2(WINDOW_DEPTH);
   localparam int SUM_W      = SAMPLE_BITS + DEPTH_LOG;
   localparam int MEAN_SHIFT = SUM_W + DEPTH_LOG;
   localparam int PROD_W     = 2 * SUM_W + 1;
   localparam logic [MEAN_SHIFT+1:0] RECIP_FULL =
      (((MEAN_SHIFT+2)'(1) << MEAN_SHIFT) + (MEAN_SHIFT+2)'(WINDOW_DEPTH - 1))
      / (MEAN_SHIFT+2)'(WINDOW_DEPTH);
   localparam logic [SUM_W:0] RECIP = RECIP_FULL[SUM_W:0];

   logic [SAMPLE_BITS-1:0] tap [WINDOW_DEPTH];
   logic [SUM_W-1:0]       sum_ff;
   logic [SUM_W-1:0]       sum_in;
   logic [SAMPLE_BITS-1:0] mean_ff;
   logic [SAMPLE_BITS-1:0] mean_in;
   logic [PROD_W-1:0]      prod;

   genvar gi;
   generate
      for (gi = 0; gi < WINDOW_DEPTH; gi++) begin : g_cell
         if (gi == 0) begin : g_head
            srrma_cell u_cell (
               .clock (clock),
               .reset (reset),
               .shift (ctrl.push),
               .d_in  (sample_in),
               .q_out (tap[gi])
            );
         end else begin : g_body
            srrma_cell u_cell (
               .clock (clock),
               .reset (reset),
               .shift (ctrl.push),
               .d_in  (tap[gi-1]),
               .q_out (tap[gi])
            );
         end
      end
   endgenerate

   always_comb begin
      sum_in = sum_ff;
      if (ctrl.push) begin
         sum_in = sum_ff + SUM_W'(sample_in) - SUM_W'(tap[WINDOW_DEPTH-1]);
      end
      prod    = PROD_W'(sum_ff) * PROD_W'(RECIP);
      mean_in = ctrl.load ? prod[MEAN_SHIFT +: SAMPLE_BITS] : mean_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         mean_ff <= '0;
      end else begin
         sum_ff  <= sum_in;
         mean_ff <= mean_in;
      end
   end

   assign mean_out = mean_ff;

   `SRRMA_ASSERT_NOW(a_push_load_apart, clock, reset, ctrl.push, !ctrl.load)
   `SRRMA_ASSERT_NEXT(a_sum_hold, clock, reset, !ctrl.push, sum_ff == $past(sum_ff))

endmodule
